// File: rtl/core/rmv_pkg.sv
package rmv_pkg;

	localparam int SAMPLE_WIDTH = 32;
	localparam int FRAC_BITS    = 16;
	localparam int COUNT_WIDTH  = 32;

	// Fixed widths of the channel fields.
	localparam int SAMPLE_IN_W = 32;
	localparam int COUNT_OUT_W = 32;
	localparam int MEAN_BITS   = 48;
	localparam int M2_W        = 64;

	localparam int FX_W   = SAMPLE_WIDTH + FRAC_BITS;
	// Signed working width: room for delta and for mean plus quotient.
	localparam int WIDE_W = ((FX_W > MEAN_BITS) ? FX_W : MEAN_BITS) + 2;
	localparam int MAG_W  = WIDE_W - 1;
	localparam int PROD_W = 2 * MAG_W;

	// Multiplier digit size and number of digits of the second operand.
	localparam int DIG_W = 16;
	localparam int NDIG  = (MAG_W + DIG_W - 1) / DIG_W;
	localparam int K_W   = (NDIG > 1) ? $clog2(NDIG) : 1;

	localparam int STEP_W = $clog2(MAG_W + 1);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [M2_W-1:0]        M2_MAX    = {M2_W{1'b1}};

	localparam logic signed [WIDE_W-1:0] MEAN_MAX_W =
		WIDE_W'({1'b0, {(MEAN_BITS-1){1'b1}}});
	localparam logic signed [WIDE_W-1:0] MEAN_MIN_W = -MEAN_MAX_W - WIDE_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_DSTART,
		ST_DIV,
		ST_SUM,
		ST_CLAMP,
		ST_MSTART,
		ST_MUL,
		ST_UPDATE
	} rmv_state_t;

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] n;
		n = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		return n[MAG_W-1:0];
	endfunction

endpackage

// File: rtl/core/rmv_in_if.sv
interface rmv_in_if;
	import rmv_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_IN_W-1:0] sample_value;

	modport source(output valid, output sample_value, input ready);
	modport sink(input valid, input sample_value, output ready);
endinterface

// File: rtl/core/rmv_out_if.sv
interface rmv_out_if;
	import rmv_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [COUNT_OUT_W-1:0]      sample_count;
	logic signed [MEAN_BITS-1:0] mean_value;
	logic [M2_W-1:0]             deviation_sum;

	modport source(output valid, output sample_count, output mean_value,
		output deviation_sum, input ready);
	modport sink(input valid, input sample_count, input mean_value,
		input deviation_sum, output ready);
endinterface

// File: rtl/core/running_mean_variance.sv
// Channel     Dir  Fields
// sample_in   in   sample_value (32, signed)
// stats_out   out  sample_count (32), mean_value (48, signed), deviation_sum (64)
//
// Each sample passes through the serial divider, which produces one quotient bit
// of delta / count per cycle, and then through a four-digit multiply.
// sample_in is ready only while the sequencer is idle; the finished result sits
// in an output register, so a new sample is taken while that beat waits.
// arst_n clears count, mean and M2 to zero and empties the output register.
module running_mean_variance (
	input  logic      clk,
	input  logic      arst_n,
	rmv_in_if.sink    sample_in,
	rmv_out_if.source stats_out
);
	import rmv_pkg::*;

	rmv_state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0]  count_q;
	logic signed [MEAN_BITS-1:0] mean_q;
	logic [M2_W-1:0]         m2_q;

	logic signed [WIDE_W-1:0] sample_fx_q;
	logic signed [WIDE_W-1:0] delta_q;
	logic signed [WIDE_W-1:0] quo_q;
	logic signed [WIDE_W-1:0] nm_q;
	logic signed [WIDE_W-1:0] resid_q;

	logic                        out_valid_q;
	logic [COUNT_OUT_W-1:0]      out_count_q;
	logic signed [MEAN_BITS-1:0] out_mean_q;
	logic [M2_W-1:0]             out_m2_q;

	logic in_ready;
	logic div_start, mul_start, div_done, mul_done;
	logic out_load;
	logic [MAG_W-1:0]  div_quo;
	logic [PROD_W-1:0] mul_prod;

	logic [COUNT_WIDTH-1:0]   count_next;
	logic signed [WIDE_W-1:0] sample_fx_now;
	logic signed [WIDE_W-1:0] mean_clamp;
	logic [M2_W-1:0]          inc;
	logic                     negative;
	logic [M2_W:0]            m2_sum;
	logic [M2_W:0]            m2_diff;
	logic [M2_W-1:0]          m2_next;

	assign count_next    = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	assign sample_fx_now = WIDE_W'(signed'(sample_in.sample_value[SAMPLE_WIDTH-1:0]))
		<<< FRAC_BITS;

	always_comb begin
		if (nm_q > MEAN_MAX_W) begin
			mean_clamp = MEAN_MAX_W;
		end else if (nm_q < MEAN_MIN_W) begin
			mean_clamp = MEAN_MIN_W;
		end else begin
			mean_clamp = nm_q;
		end
	end

	// Scaled product saturates when any bit above the 64-bit window is set.
	always_comb begin
		if (|mul_prod[PROD_W-1:FRAC_BITS+M2_W]) begin
			inc = M2_MAX;
		end else begin
			inc = mul_prod[FRAC_BITS +: M2_W];
		end
		negative = delta_q[WIDE_W-1] ^ resid_q[WIDE_W-1];
		m2_sum   = {1'b0, m2_q} + {1'b0, inc};
		m2_diff  = {1'b0, m2_q} - {1'b0, inc};
		if (negative) begin
			m2_next = (m2_diff[M2_W] || (m2_diff == '0)) ? '0 : m2_diff[M2_W-1:0];
		end else begin
			m2_next = m2_sum[M2_W] ? M2_MAX : m2_sum[M2_W-1:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (sample_in.valid) begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA:  state_d = ST_DSTART;
			ST_DSTART: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM:    state_d = ST_CLAMP;
			ST_CLAMP:  state_d = ST_MSTART;
			ST_MSTART: begin
				mul_start = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				if (mul_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!out_valid_q || stats_out.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			mean_q      <= '0;
			m2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready && sample_in.valid) begin
				count_q <= count_next;
			end
			if (state_q == ST_CLAMP) begin
				mean_q <= mean_clamp[MEAN_BITS-1:0];
			end
			if (out_load) begin
				m2_q        <= m2_next;
				out_valid_q <= 1'b1;
			end else if (stats_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && sample_in.valid) begin
			sample_fx_q <= sample_fx_now;
		end
		case (state_q)
			ST_DELTA: delta_q <= sample_fx_q - WIDE_W'(mean_q);
			ST_DIV: begin
				if (div_done) begin
					// Quotient truncates toward zero: divide magnitudes, restore sign.
					quo_q <= delta_q[WIDE_W-1] ? -WIDE_W'(div_quo) : WIDE_W'(div_quo);
				end
			end
			ST_SUM:   nm_q    <= WIDE_W'(mean_q) + quo_q;
			ST_CLAMP: resid_q <= sample_fx_q - mean_clamp;
			default: begin
			end
		endcase
		if (out_load) begin
			out_count_q <= COUNT_OUT_W'(count_q);
			out_mean_q  <= mean_q;
			out_m2_q    <= m2_next;
		end
	end

	rmv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_of(delta_q)),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	rmv_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mag_of(delta_q)),
		.b       (mag_of(resid_q)),
		.done    (mul_done),
		.product (mul_prod)
	);

	assign sample_in.ready         = in_ready;
	assign stats_out.valid         = out_valid_q;
	assign stats_out.sample_count  = out_count_q;
	assign stats_out.mean_value    = out_mean_q;
	assign stats_out.deviation_sum = out_m2_q;
endmodule

// File: rtl/core/rmv_div.sv
module rmv_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rmv_pkg::MAG_W-1:0]       dividend,
	input  logic [rmv_pkg::COUNT_WIDTH-1:0] divisor,
	output logic                            done,
	output logic [rmv_pkg::MAG_W-1:0]       quotient
);
	import rmv_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [STEP_W-1:0]      step_q;
	logic [MAG_W-1:0]       quo_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [COUNT_WIDTH-1:0] dvs_q;

	logic [COUNT_WIDTH:0] trial;
	logic [COUNT_WIDTH:0] diff;
	logic                 fits;

	// Restoring division, one quotient bit a cycle, dividend shifted out MSB first.
	always_comb begin
		trial = {rem_q, quo_q[MAG_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(MAG_W);
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MAG_W-2:0], fits};
			rem_q <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: rtl/core/rmv_mul.sv
module rmv_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rmv_pkg::MAG_W-1:0]  a,
	input  logic [rmv_pkg::MAG_W-1:0]  b,
	output logic                       done,
	output logic [rmv_pkg::PROD_W-1:0] product
);
	import rmv_pkg::*;

	logic                      issue_q;
	logic [K_W-1:0]            k_q;
	logic [MAG_W-1:0]          a_q;
	logic [NDIG*DIG_W-1:0]     b_q;
	logic                      pp_vld_s1;
	logic                      last_s1;
	logic [K_W-1:0]            k_s1;
	logic [MAG_W+DIG_W-1:0]    pp_s1;
	logic [PROD_W-1:0]         acc_q;
	logic                      done_q;

	// One digit of b per cycle is multiplied; the partial product is added
	// in the following cycle at its digit position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q   <= 1'b0;
			k_q       <= '0;
			pp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else if (start) begin
			issue_q   <= 1'b1;
			k_q       <= '0;
			pp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			pp_vld_s1 <= issue_q;
			done_q    <= pp_vld_s1 && last_s1;
			if (issue_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == K_W'(NDIG - 1)) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= (NDIG*DIG_W)'(b);
			acc_q <= '0;
		end else begin
			if (issue_q) begin
				pp_s1   <= a_q * b_q[DIG_W-1:0];
				k_s1    <= k_q;
				last_s1 <= (k_q == K_W'(NDIG - 1));
				b_q     <= b_q >> DIG_W;
			end
			if (pp_vld_s1) begin
				acc_q <= acc_q + (PROD_W'(pp_s1) << (DIG_W * k_s1));
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule
